// ===== design/sm83_pkg.sv =====
package sm83_pkg;

  typedef enum logic [1:0] {
    KIND_READ   = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_RETIRE = 2'd2
  } kind_t;

  localparam logic [3:0] FLAG_Z = 4'b1000;
  localparam logic [3:0] FLAG_N = 4'b0100;
  localparam logic [3:0] FLAG_H = 4'b0010;
  localparam logic [3:0] FLAG_C = 4'b0001;

  localparam logic [7:0]  RST_A     = 8'h01;
  localparam logic [3:0]  RST_FLAGS = 4'hB;
  localparam logic [15:0] RST_BC    = 16'h0013;
  localparam logic [15:0] RST_DE    = 16'h00D8;
  localparam logic [15:0] RST_HL    = 16'h014D;
  localparam logic [15:0] RST_SP    = 16'hFFFE;
  localparam logic [15:0] RST_PC    = 16'h0100;

  // Input item as it travels from the front end to the execute stage
  typedef struct packed {
    logic       op;
    logic [7:0] opcode;
    logic [7:0] imm_low;
    logic [7:0] imm_high;
    logic [7:0] read_data;
  } item_t;

  // One result item
  typedef struct packed {
    kind_t       kind;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic        last;
    logic [15:0] prog_counter;
    logic [3:0]  flag_bits;
    logic [7:0]  accum;
  } res_t;

endpackage

// ===== design/sm83_front.sv =====
// Input queue between the port and the execute stage
module sm83_front
  import sm83_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  take,
  output logic  avail,
  output item_t head
);

  item_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign avail = (cnt_r != 2'd0);
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) mem_r[wp_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push && !full) wp_r <= ~wp_r;
      if (take && avail) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push && !full) - 2'(take && avail);
    end
  end

endmodule

// ===== design/sm83_exec.sv =====
// Executes one item per cycle while the queue has room; emits up to three results
module sm83_exec
  import sm83_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  avail,
  input  item_t item,
  output logic  take,
  output logic  out_empty,
  output res_t  out_res,
  input  logic  out_pop
);

  logic [7:0]  a_r, a_nxt;
  logic [3:0]  f_r, f_nxt;
  logic [15:0] bc_r, bc_nxt, de_r, de_nxt, hl_r, hl_nxt, sp_r, sp_nxt, pc_r, pc_nxt;
  logic        pv_r, pv_nxt;
  logic [7:0]  po_r, po_nxt;

  // output queue, 4 entries
  res_t        q_r [4];
  logic [1:0]  qw_r, qr_r;
  logic [2:0]  qc_r;

  logic [1:0]  n;
  kind_t       k0, k1;
  logic [15:0] ad0, ad1;
  logic [7:0]  wd0, wd1;

  assign take      = avail && (qc_r <= 3'd1);
  assign out_empty = (qc_r == 3'd0);
  assign out_res   = q_r[qr_r];

  function automatic logic [7:0] r8(input logic [2:0] c, input logic [15:0] bc,
                                    input logic [15:0] de, input logic [15:0] hl,
                                    input logic [7:0] a);
    logic [7:0] v;
    unique case (c)
      3'd0: v = bc[15:8];
      3'd1: v = bc[7:0];
      3'd2: v = de[15:8];
      3'd3: v = de[7:0];
      3'd4: v = hl[15:8];
      3'd5: v = hl[7:0];
      3'd7: v = a;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  always_comb begin
    logic [7:0]  op, lo, hi, d, src_v, b, r, rot;
    logic [2:0]  dst, src, sel;
    logic [15:0] imm16, off, pv16, addr;
    logic [16:0] s17;
    logic [12:0] s13;
    logic [8:0]  s9, bc9;
    logic [4:0]  s5, bc5;
    logic        c, cout, cnd, dec, wr_r8, do_alu, do_id;
    logic [7:0]  id_v, id_r, wv;
    logic [3:0]  id_f, af;
    a_nxt = a_r; f_nxt = f_r; bc_nxt = bc_r; de_nxt = de_r; hl_nxt = hl_r;
    sp_nxt = sp_r; pc_nxt = pc_r; pv_nxt = pv_r; po_nxt = po_r;
    n = 2'd0; k0 = KIND_RETIRE; k1 = KIND_RETIRE;
    ad0 = 16'h0; ad1 = 16'h0; wd0 = 8'h0; wd1 = 8'h0;
    op = item.opcode; lo = item.imm_low; hi = item.imm_high; d = item.read_data;
    dst = op[5:3]; src = op[2:0];
    imm16 = {hi, lo};
    off = {{8{lo[7]}}, lo};
    unique case (op[5:4])
      2'd0: pv16 = bc_r;
      2'd1: pv16 = de_r;
      2'd2: pv16 = hl_r;
      default: pv16 = sp_r;
    endcase
    addr = (op[5:4] == 2'd0) ? bc_r : (op[5:4] == 2'd1) ? de_r : hl_r;
    src_v = r8(src, bc_r, de_r, hl_r, a_r);
    wr_r8 = 1'b0; wv = 8'h00; do_alu = 1'b0; b = src_v; do_id = 1'b0;
    dec = op[0]; id_v = r8(dst, bc_r, de_r, hl_r, a_r);
    sel = dst;
    if (!item.op) begin
      pv_nxt = 1'b0;
      pc_nxt = pc_r + 16'd1;
      n = 2'd1;
      if (op < 8'h40) begin
        if (op == 8'h08) begin
          pc_nxt = pc_r + 16'd3;
          n = 2'd3; k0 = KIND_WRITE; k1 = KIND_WRITE;
          ad0 = imm16; ad1 = imm16 + 16'd1; wd0 = sp_r[7:0]; wd1 = sp_r[15:8];
        end else if (op == 8'h18 || (op & 8'hE7) == 8'h20) begin
          cnd = op[4] ? f_r[0] : f_r[3];
          cnd = op[3] ? cnd : !cnd;
          pc_nxt = pc_r + 16'd2 + ((op == 8'h18 || cnd) ? off : 16'h0);
        end else if ((op & 8'hCF) == 8'h01) begin
          pc_nxt = pc_r + 16'd3;
          unique case (op[5:4])
            2'd0: bc_nxt = imm16;
            2'd1: de_nxt = imm16;
            2'd2: hl_nxt = imm16;
            default: sp_nxt = imm16;
          endcase
        end else if (src == 3'd6) begin
          pc_nxt = pc_r + 16'd2;
          if (dst == 3'd6) begin
            n = 2'd2; k0 = KIND_WRITE; ad0 = hl_r; wd0 = lo;
          end else begin
            wr_r8 = 1'b1; wv = lo;
          end
        end else if ((op & 8'hCF) == 8'h09) begin
          s13 = {1'b0, hl_r[11:0]} + {1'b0, pv16[11:0]};
          s17 = {1'b0, hl_r} + {1'b0, pv16};
          hl_nxt = s17[15:0];
          f_nxt = (f_r & FLAG_Z) | (s13[12] ? FLAG_H : 4'h0) | (s17[16] ? FLAG_C : 4'h0);
        end else if ((op & 8'hC7) == 8'h02) begin
          if (op[5:4] == 2'd2) hl_nxt = hl_r + 16'd1;
          if (op[5:4] == 2'd3) hl_nxt = hl_r - 16'd1;
          if (op[3]) begin
            pv_nxt = 1'b1; po_nxt = op; k0 = KIND_READ; ad0 = addr;
          end else begin
            n = 2'd2; k0 = KIND_WRITE; ad0 = addr; wd0 = a_r;
          end
        end else if ((op & 8'hC7) == 8'h03) begin
          unique case (op[5:4])
            2'd0: bc_nxt = op[3] ? bc_r - 16'd1 : bc_r + 16'd1;
            2'd1: de_nxt = op[3] ? de_r - 16'd1 : de_r + 16'd1;
            2'd2: hl_nxt = op[3] ? hl_r - 16'd1 : hl_r + 16'd1;
            default: sp_nxt = op[3] ? sp_r - 16'd1 : sp_r + 16'd1;
          endcase
        end else if ((op & 8'hC6) == 8'h04) begin
          if (dst == 3'd6) begin
            pv_nxt = 1'b1; po_nxt = op; k0 = KIND_READ; ad0 = hl_r;
          end else begin
            do_id = 1'b1;
          end
        end else if ((op & 8'hE7) == 8'h07) begin
          if (op[3]) begin
            cout = a_r[0];
            rot = {op[4] ? f_r[0] : cout, a_r[7:1]};
          end else begin
            cout = a_r[7];
            rot = {a_r[6:0], op[4] ? f_r[0] : cout};
          end
          a_nxt = rot; f_nxt = {3'b000, cout};
        end else if (op == 8'h2F) begin
          a_nxt = ~a_r; f_nxt = f_r | FLAG_N | FLAG_H;
        end else if (op == 8'h37) begin
          f_nxt = (f_r & FLAG_Z) | FLAG_C;
        end else if (op == 8'h3F) begin
          f_nxt = (f_r & FLAG_Z) | ((f_r & FLAG_C) ^ FLAG_C);
        end
      end else if (op < 8'h80 && op != 8'h76) begin
        if (src == 3'd6) begin
          pv_nxt = 1'b1; po_nxt = op; k0 = KIND_READ; ad0 = hl_r;
        end else if (dst == 3'd6) begin
          n = 2'd2; k0 = KIND_WRITE; ad0 = hl_r; wd0 = src_v;
        end else begin
          wr_r8 = 1'b1; wv = src_v;
        end
      end else if (op >= 8'h80 && op < 8'hC0) begin
        if (src == 3'd6) begin
          pv_nxt = 1'b1; po_nxt = op; k0 = KIND_READ; ad0 = hl_r;
        end else begin
          do_alu = 1'b1;
        end
      end
    end else if (pv_r) begin
      // complete the pending access with the returned byte
      pv_nxt = 1'b0;
      n = 2'd1;
      dst = po_r[5:3]; sel = po_r[5:3]; b = d;
      if (po_r == 8'h34 || po_r == 8'h35) begin
        do_id = 1'b1; dec = po_r[0]; id_v = d;
        n = 2'd2; k0 = KIND_WRITE; ad0 = hl_r;
      end else if ((po_r & 8'hE7) == 8'h0A) begin
        a_nxt = d;
      end else if (po_r >= 8'h40 && po_r < 8'h80) begin
        wr_r8 = 1'b1; wv = d;
      end else if (po_r >= 8'h80 && po_r < 8'hC0) begin
        do_alu = 1'b1;
      end
    end
    // INC/DEC 8-bit
    id_r = dec ? id_v - 8'd1 : id_v + 8'd1;
    id_f = (f_r & FLAG_C) | (dec ? FLAG_N : 4'h0)
         | ((dec ? (id_v[3:0] == 4'h0) : (id_v[3:0] == 4'hF)) ? FLAG_H : 4'h0)
         | ((id_r == 8'h00) ? FLAG_Z : 4'h0);
    if (do_id) begin
      f_nxt = id_f;
      if (item.op) wd0 = id_r;
      else begin
        wr_r8 = 1'b1; wv = id_r;
      end
    end
    // ALU
    c = (sel == 3'd1 || sel == 3'd3) ? f_r[0] : 1'b0;
    bc5 = {1'b0, b[3:0]} + {4'h0, c};
    bc9 = {1'b0, b} + {8'h00, c};
    s5 = {1'b0, a_r[3:0]} + bc5;
    s9 = {1'b0, a_r} + bc9;
    af = 4'h0;
    unique case (sel)
      3'd0, 3'd1: begin
        r = s9[7:0];
        af = (s5[4] ? FLAG_H : 4'h0) | (s9[8] ? FLAG_C : 4'h0);
      end
      3'd2, 3'd3, 3'd7: begin
        r = a_r - b - {7'h0, c};
        af = FLAG_N | (({1'b0, a_r[3:0]} < bc5) ? FLAG_H : 4'h0)
           | (({1'b0, a_r} < bc9) ? FLAG_C : 4'h0);
      end
      3'd4: begin
        r = a_r & b; af = FLAG_H;
      end
      3'd5: r = a_r ^ b;
      default: r = a_r | b;
    endcase
    if (r == 8'h00) af = af | FLAG_Z;
    if (do_alu) begin
      f_nxt = af;
      if (sel != 3'd7) a_nxt = r;
    end
    if (wr_r8) begin
      unique case (dst)
        3'd0: bc_nxt = {wv, bc_r[7:0]};
        3'd1: bc_nxt = {bc_r[15:8], wv};
        3'd2: de_nxt = {wv, de_r[7:0]};
        3'd3: de_nxt = {de_r[15:8], wv};
        3'd4: hl_nxt = {wv, hl_r[7:0]};
        3'd5: hl_nxt = {hl_r[15:8], wv};
        3'd7: a_nxt = wv;
        default: ;
      endcase
    end
  end

  logic fire;
  assign fire = take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r <= RST_A; f_r <= RST_FLAGS; bc_r <= RST_BC; de_r <= RST_DE;
      hl_r <= RST_HL; sp_r <= RST_SP; pc_r <= RST_PC; pv_r <= 1'b0;
      po_r <= 8'h00;
      qw_r <= 2'd0; qr_r <= 2'd0; qc_r <= 3'd0;
    end else begin
      if (fire) begin
        a_r <= a_nxt; f_r <= f_nxt; bc_r <= bc_nxt; de_r <= de_nxt;
        hl_r <= hl_nxt; sp_r <= sp_nxt; pc_r <= pc_nxt; pv_r <= pv_nxt;
        po_r <= po_nxt;
        qw_r <= qw_r + n;
      end
      if (!out_empty && out_pop) qr_r <= qr_r + 2'd1;
      qc_r <= qc_r + (fire ? {1'b0, n} : 3'd0) - 3'(!out_empty && out_pop);
    end
  end

  // write up to three results, final one carries last
  always_ff @(posedge clk) begin
    if (fire) begin
      if (n != 2'd0)
        q_r[qw_r] <= '{kind: (n == 2'd1) ? ((k0 == KIND_READ) ? KIND_READ : KIND_RETIRE) : k0,
                       address: (n == 2'd1 && k0 != KIND_READ) ? 16'h0 : ad0,
                       write_data: (n == 2'd1) ? 8'h00 : wd0,
                       last: (n == 2'd1),
                       prog_counter: pc_nxt, flag_bits: f_nxt, accum: a_nxt};
      if (n >= 2'd2)
        q_r[qw_r + 2'd1] <= '{kind: (n == 2'd2) ? KIND_RETIRE : k1,
                              address: (n == 2'd2) ? 16'h0 : ad1,
                              write_data: (n == 2'd2) ? 8'h00 : wd1,
                              last: (n == 2'd2),
                              prog_counter: pc_nxt, flag_bits: f_nxt, accum: a_nxt};
      if (n == 2'd3)
        q_r[qw_r + 2'd2] <= '{kind: KIND_RETIRE, address: 16'h0, write_data: 8'h00,
                              last: 1'b1, prog_counter: pc_nxt, flag_bits: f_nxt,
                              accum: a_nxt};
    end
  end

endmodule

// ===== design/sm83_cpu_execute_subset_unit.sv =====
// SM83 subset executor (opcodes 0x00-0xBF; DAA, STOP, HALT and 0xC0-0xFF act as NOP).
// An item is one new instruction or the read data for a pending memory access; each
// gives up to three results (read request, write requests, retire) on a queue-style
// output. A two-entry input queue feeds an execute stage whose register file and
// flags update when an item is taken, so items can follow back to back: one item per
// cycle while the four-entry result queue has room for three more, i.e. the rate is
// set by how fast results are popped (one result per cycle).
module sm83_cpu_execute_subset_unit
  import sm83_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic        in_op,
  input  logic [7:0]  in_opcode,
  input  logic [7:0]  in_imm_low,
  input  logic [7:0]  in_imm_high,
  input  logic [7:0]  in_read_data,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_kind,
  output logic [15:0] out_address,
  output logic [7:0]  out_write_data,
  output logic        out_last,
  output logic [15:0] out_prog_counter,
  output logic [3:0]  out_flag_bits,
  output logic [7:0]  out_accum
);

  item_t in_item, head;
  logic  avail, take;
  res_t  res;

  assign in_item = '{op: in_op, opcode: in_opcode, imm_low: in_imm_low,
                     imm_high: in_imm_high, read_data: in_read_data};

  sm83_front u_front (
    .clk(clk), .rst_n(rst_n), .push(push), .push_item(in_item), .full(full),
    .take(take), .avail(avail), .head(head)
  );

  sm83_exec u_exec (
    .clk(clk), .rst_n(rst_n), .avail(avail), .item(head), .take(take),
    .out_empty(empty), .out_res(res), .out_pop(pop)
  );

  assign out_kind         = res.kind;
  assign out_address      = res.address;
  assign out_write_data   = res.write_data;
  assign out_last         = res.last;
  assign out_prog_counter = res.prog_counter;
  assign out_flag_bits    = res.flag_bits;
  assign out_accum        = res.accum;

endmodule

// ===== test/sm83_cpu_execute_subset_unit_test.sv =====
module sm83_cpu_execute_subset_unit_test;
  import sm83_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 350;
  localparam logic OP_EXEC = 1'b0;
  localparam logic OP_DATA = 1'b1;

  // Opcodes used by name in the directed table and the prediction tasks
  localparam logic [7:0] OPC_NOP      = 8'h00;
  localparam logic [7:0] OPC_LD_U16SP = 8'h08;
  localparam logic [7:0] OPC_LD_HL16  = 8'h21;
  localparam logic [7:0] OPC_LD_A_HLI = 8'h2A;
  localparam logic [7:0] OPC_INC_MHL  = 8'h34;
  localparam logic [7:0] OPC_DEC_MHL  = 8'h35;
  localparam logic [7:0] OPC_LD_MHL_N = 8'h36;
  localparam logic [7:0] OPC_JR       = 8'h18;
  localparam logic [7:0] OPC_JR_NZ    = 8'h20;
  localparam logic [7:0] OPC_ADD_HLSP = 8'h39;
  localparam logic [7:0] OPC_CPL      = 8'h2F;
  localparam logic [7:0] OPC_SCF      = 8'h37;
  localparam logic [7:0] OPC_CCF      = 8'h3F;
  localparam logic [7:0] OPC_RRA      = 8'h1F;
  localparam logic [7:0] OPC_HALT     = 8'h76;
  localparam logic [7:0] OPC_LD_B_MHL = 8'h46;
  localparam logic [7:0] OPC_ADC_MHL  = 8'h8E;
  localparam logic [7:0] OPC_CP_MHL   = 8'hBE;
  localparam logic [7:0] OPC_SBC_A    = 8'h9F;
  localparam logic [7:0] OPC_LAST     = 8'hFF;

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic        in_op;
  logic [7:0]  in_opcode;
  logic [7:0]  in_imm_low;
  logic [7:0]  in_imm_high;
  logic [7:0]  in_read_data;
  logic        empty;
  logic        pop;
  logic [1:0]  out_kind;
  logic [15:0] out_address;
  logic [7:0]  out_write_data;
  logic        out_last;
  logic [15:0] out_prog_counter;
  logic [3:0]  out_flag_bits;
  logic [7:0]  out_accum;

  sm83_cpu_execute_subset_unit DUT (.*);

  // Architectural state as the core should hold it
  logic [7:0]  cpu_a;
  logic [3:0]  cpu_f;
  logic [15:0] cpu_bc, cpu_de, cpu_hl, cpu_sp, cpu_pc;
  logic        access_pending;
  logic [7:0]  access_opcode;

  res_t step_res[$];
  res_t expected_results[$];

  int errors;
  int mismatches;
  int send_idle_pct;
  int recv_idle_pct;
  bit recv_hold;
  int sent;

  typedef struct {
    logic       op;
    logic [7:0] opcode;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] rd;
    bit         typed;
    res_t       want;
  } directed_row_t;

  directed_row_t table_rows[$];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  function automatic logic [7:0] read_r8(input logic [2:0] code);
    case (code)
      3'd0: return cpu_bc[15:8];
      3'd1: return cpu_bc[7:0];
      3'd2: return cpu_de[15:8];
      3'd3: return cpu_de[7:0];
      3'd4: return cpu_hl[15:8];
      3'd5: return cpu_hl[7:0];
      3'd7: return cpu_a;
      default: return 8'h00;
    endcase
  endfunction

  task automatic write_r8(input logic [2:0] code, input logic [7:0] v);
    case (code)
      3'd0: cpu_bc[15:8] = v;
      3'd1: cpu_bc[7:0] = v;
      3'd2: cpu_de[15:8] = v;
      3'd3: cpu_de[7:0] = v;
      3'd4: cpu_hl[15:8] = v;
      3'd5: cpu_hl[7:0] = v;
      3'd7: cpu_a = v;
      default: ;
    endcase
  endtask

  function automatic logic [15:0] read_pair(input logic [1:0] code);
    case (code)
      2'd0: return cpu_bc;
      2'd1: return cpu_de;
      2'd2: return cpu_hl;
      default: return cpu_sp;
    endcase
  endfunction

  task automatic write_pair(input logic [1:0] code, input logic [15:0] v);
    case (code)
      2'd0: cpu_bc = v;
      2'd1: cpu_de = v;
      2'd2: cpu_hl = v;
      default: cpu_sp = v;
    endcase
  endtask

  task automatic note(input kind_t k, input logic [15:0] addr, input logic [7:0] data);
    res_t r;
    r = '0;
    r.kind = k;
    r.address = addr;
    r.write_data = data;
    step_res.push_back(r);
  endtask

  function automatic logic [7:0] step_incdec(input logic [7:0] v, input bit dec);
    logic [7:0] r;
    logic [3:0] f;
    f = cpu_f & FLAG_C;
    if (dec) begin
      r = v - 8'd1;
      f |= FLAG_N;
      if (v[3:0] == 4'h0) f |= FLAG_H;
    end else begin
      r = v + 8'd1;
      if (v[3:0] == 4'hF) f |= FLAG_H;
    end
    if (r == 8'h00) f |= FLAG_Z;
    cpu_f = f;
    return r;
  endfunction

  task automatic run_alu(input logic [2:0] sel, input logic [7:0] b);
    logic [8:0] c;
    logic [9:0] r;
    logic [3:0] f;
    c = (sel == 3'd1 || sel == 3'd3) ? {8'd0, cpu_f[0]} : 9'd0;
    f = '0;
    case (sel)
      3'd0, 3'd1: begin
        r = cpu_a + b + c;
        if ({1'b0, cpu_a[3:0]} + b[3:0] + c > 9'h0F) f |= FLAG_H;
        if (r > 10'hFF) f |= FLAG_C;
      end
      3'd2, 3'd3, 3'd7: begin
        r = cpu_a - b - c;
        f |= FLAG_N;
        if ({5'd0, cpu_a[3:0]} < {5'd0, b[3:0]} + c) f |= FLAG_H;
        if ({1'b0, cpu_a} < b + c) f |= FLAG_C;
      end
      3'd4: begin
        r = cpu_a & b;
        f |= FLAG_H;
      end
      3'd5: r = cpu_a ^ b;
      default: r = cpu_a | b;
    endcase
    if (r[7:0] == 8'h00) f |= FLAG_Z;
    cpu_f = f;
    if (sel != 3'd7) cpu_a = r[7:0];
  endtask

  task automatic finish_access(input logic [7:0] opc, input logic [7:0] d);
    logic [7:0] r;
    if (opc == OPC_INC_MHL || opc == OPC_DEC_MHL) begin
      r = step_incdec(d, opc[0]);
      note(KIND_WRITE, cpu_hl, r);
    end else if ((opc & 8'hE7) == 8'h0A) cpu_a = d;
    else if (opc >= 8'h40 && opc < 8'h80) write_r8(opc[5:3], d);
    else if (opc >= 8'h80 && opc < 8'hC0) run_alu(opc[5:3], d);
    note(KIND_RETIRE, 16'h0, 8'h00);
  endtask

  // Execute a new instruction; returns early on a read request
  task automatic run_opcode(input logic [7:0] opc, input logic [7:0] lo, input logic [7:0] hi);
    logic [15:0] imm16, addr, pv;
    logic [2:0]  dst, src;
    logic [1:0]  sel;
    logic [16:0] sum;
    logic [3:0]  f;
    logic        cin, cout, taken;
    imm16 = {hi, lo};
    dst = opc[5:3];
    src = opc[2:0];
    sel = opc[5:4];
    if (opc < 8'h40) begin
      if (opc == OPC_LD_U16SP) begin
        cpu_pc += 16'd3;
        note(KIND_WRITE, imm16, cpu_sp[7:0]);
        note(KIND_WRITE, imm16 + 16'd1, cpu_sp[15:8]);
        note(KIND_RETIRE, 16'h0, 8'h00);
        return;
      end
      if (opc == OPC_JR || (opc & 8'hE7) == 8'h20) begin
        cpu_pc += 16'd2;
        taken = (opc[4] ? cpu_f[0] : cpu_f[3]) == opc[3];
        if (opc == OPC_JR || taken) cpu_pc += {{8{lo[7]}}, lo};
        note(KIND_RETIRE, 16'h0, 8'h00);
        return;
      end
      if ((opc & 8'hCF) == 8'h01) begin
        write_pair(sel, imm16);
        cpu_pc += 16'd3;
        note(KIND_RETIRE, 16'h0, 8'h00);
        return;
      end
      if (src == 3'd6) begin
        cpu_pc += 16'd2;
        if (dst == 3'd6) note(KIND_WRITE, cpu_hl, lo);
        else write_r8(dst, lo);
        note(KIND_RETIRE, 16'h0, 8'h00);
        return;
      end
      cpu_pc += 16'd1;
      if ((opc & 8'hCF) == 8'h09) begin
        pv = read_pair(sel);
        f = cpu_f & FLAG_Z;
        if ({1'b0, cpu_hl[11:0]} + pv[11:0] > 13'hFFF) f |= FLAG_H;
        sum = cpu_hl + pv;
        if (sum[16]) f |= FLAG_C;
        cpu_hl = sum[15:0];
        cpu_f = f;
      end else if ((opc & 8'hC7) == 8'h02) begin
        addr = (sel == 2'd0) ? cpu_bc : (sel == 2'd1) ? cpu_de : cpu_hl;
        if (!opc[3]) note(KIND_WRITE, addr, cpu_a);
        if (sel == 2'd2) cpu_hl += 16'd1;
        if (sel == 2'd3) cpu_hl -= 16'd1;
        if (opc[3]) begin
          access_pending = 1'b1;
          access_opcode = opc;
          note(KIND_READ, addr, 8'h00);
          return;
        end
      end else if ((opc & 8'hC7) == 8'h03) begin
        pv = read_pair(sel);
        write_pair(sel, opc[3] ? pv - 16'd1 : pv + 16'd1);
      end else if ((opc & 8'hC6) == 8'h04) begin
        if (dst == 3'd6) begin
          access_pending = 1'b1;
          access_opcode = opc;
          note(KIND_READ, cpu_hl, 8'h00);
          return;
        end
        write_r8(dst, step_incdec(read_r8(dst), opc[0]));
      end else if ((opc & 8'hE7) == 8'h07) begin
        cin = cpu_f[0];
        if (opc[3]) begin
          cout = cpu_a[0];
          cpu_a = {opc[4] ? cin : cout, cpu_a[7:1]};
        end else begin
          cout = cpu_a[7];
          cpu_a = {cpu_a[6:0], opc[4] ? cin : cout};
        end
        cpu_f = {3'b000, cout};
      end else if (opc == OPC_CPL) begin
        cpu_a = ~cpu_a;
        cpu_f |= FLAG_N | FLAG_H;
      end else if (opc == OPC_SCF) cpu_f = (cpu_f & FLAG_Z) | FLAG_C;
      else if (opc == OPC_CCF) cpu_f = (cpu_f & FLAG_Z) | ((cpu_f & FLAG_C) ^ FLAG_C);
      note(KIND_RETIRE, 16'h0, 8'h00);
      return;
    end
    cpu_pc += 16'd1;
    if (opc < 8'hC0 && opc != OPC_HALT) begin
      if (src == 3'd6) begin
        access_pending = 1'b1;
        access_opcode = opc;
        note(KIND_READ, cpu_hl, 8'h00);
        return;
      end
      if (opc >= 8'h80) run_alu(dst, read_r8(src));
      else if (dst == 3'd6) note(KIND_WRITE, cpu_hl, read_r8(src));
      else write_r8(dst, read_r8(src));
    end
    note(KIND_RETIRE, 16'h0, 8'h00);
  endtask

  // Predict the results of one accepted transaction
  task automatic predict_item(input logic op, input logic [7:0] opc, input logic [7:0] lo,
                              input logic [7:0] hi, input logic [7:0] rd);
    logic [7:0] p;
    step_res.delete();
    if (op == OP_DATA) begin
      if (!access_pending) return;
      p = access_opcode;
      access_pending = 1'b0;
      finish_access(p, rd);
    end else begin
      access_pending = 1'b0;
      run_opcode(opc, lo, hi);
    end
    foreach (step_res[i]) begin
      step_res[i].last = (i == step_res.size() - 1);
      step_res[i].prog_counter = cpu_pc;
      step_res[i].flag_bits = cpu_f;
      step_res[i].accum = cpu_a;
      expected_results.push_back(step_res[i]);
    end
  endtask

  // Push stays high across back-to-back transactions and drops only while idling
  task automatic send_item(input logic op, input logic [7:0] opc, input logic [7:0] lo,
                           input logic [7:0] hi, input logic [7:0] rd);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_op <= op;
    in_opcode <= opc;
    in_imm_low <= lo;
    in_imm_high <= hi;
    in_read_data <= rd;
    do @(posedge clk); while (full);
    predict_item(op, opc, lo, hi, rd);
    sent++;
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    push <= 1'b0;
    while (expected_results.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
  endtask

  // Receiver: pop at random and compare each transaction with the oldest expectation
  always @(posedge clk) begin
    res_t want;
    if (rst_n && pop && !empty) begin
      if (expected_results.size() == 0) begin
        errors++;
        if (mismatches < 10)
          $display("unexpected result kind %0d addr %h", out_kind, out_address);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (out_kind !== want.kind || out_address !== want.address ||
            out_write_data !== want.write_data || out_last !== want.last ||
            out_prog_counter !== want.prog_counter || out_flag_bits !== want.flag_bits ||
            out_accum !== want.accum) begin
          errors++;
          if (mismatches < 10)
            $display({"mismatch: want k%0d a%h d%h l%0d pc%h f%h A%h",
                      " got k%0d a%h d%h l%0d pc%h f%h A%h"},
                     want.kind, want.address, want.write_data, want.last,
                     want.prog_counter, want.flag_bits, want.accum,
                     out_kind, out_address, out_write_data, out_last,
                     out_prog_counter, out_flag_bits, out_accum);
          mismatches++;
        end
      end
    end
    if (!rst_n) pop <= 1'b0;
    else pop <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // Long receiver hold-off so the input side fills and stalls
  task automatic hold_receiver();
    recv_hold = 1'b1;
    repeat (60) @(posedge clk);
    recv_hold = 1'b0;
  endtask

  task automatic add_row(input logic op, input logic [7:0] opc, input logic [7:0] lo,
                         input logic [7:0] hi, input logic [7:0] rd);
    directed_row_t row;
    row = '{op: op, opcode: opc, lo: lo, hi: hi, rd: rd, typed: 1'b0, want: '0};
    table_rows.push_back(row);
  endtask

  task automatic random_item();
    int pick;
    logic [7:0] opc;
    pick = $urandom_range(99);
    opc = 8'($urandom_range(8'hBF));
    if (pick < 10) opc = 8'($urandom_range(8'hFF));
    if (pick < 15)
      send_item(OP_DATA, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    else begin
      send_item(OP_EXEC, opc, 8'($urandom), 8'($urandom), 8'($urandom));
      // Answer most reads so memory operands are exercised
      if (access_pending && $urandom_range(9) < 8)
        send_item(OP_DATA, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    directed_row_t row;
    errors = 0;
    mismatches = 0;
    sent = 0;
    recv_hold = 1'b0;
    send_idle_pct = 24;
    recv_idle_pct = 79;
    rst_n = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    in_op = 1'b0;
    in_opcode = '0;
    in_imm_low = '0;
    in_imm_high = '0;
    in_read_data = '0;
    cpu_a = RST_A;
    cpu_f = RST_FLAGS;
    cpu_bc = RST_BC;
    cpu_de = RST_DE;
    cpu_hl = RST_HL;
    cpu_sp = RST_SP;
    cpu_pc = RST_PC;
    access_pending = 1'b0;
    access_opcode = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A NOP straight after reset shows the reset registers
    row = '{op: OP_EXEC, opcode: OPC_NOP, lo: 8'h00, hi: 8'h00, rd: 8'h00, typed: 1'b1,
            want: '{kind: KIND_RETIRE, address: 16'h0, write_data: 8'h00, last: 1'b1,
                    prog_counter: RST_PC + 16'd1, flag_bits: RST_FLAGS, accum: RST_A}};
    table_rows.push_back(row);
    add_row(OP_DATA, 8'h00, 8'h00, 8'h00, 8'hFF);       // stray read data: ignored
    add_row(OP_EXEC, OPC_LD_U16SP, 8'hFF, 8'hFF, 8'h00); // store wraps past top
    add_row(OP_EXEC, OPC_LD_HL16, 8'hFF, 8'hFF, 8'h00);
    add_row(OP_EXEC, OPC_LD_A_HLI, 8'h00, 8'h00, 8'h00);
    add_row(OP_DATA, 8'h00, 8'h00, 8'h00, 8'h80);
    add_row(OP_EXEC, OPC_INC_MHL, 8'h00, 8'h00, 8'h00);
    add_row(OP_DATA, 8'h00, 8'h00, 8'h00, 8'hFF);
    add_row(OP_EXEC, OPC_DEC_MHL, 8'h00, 8'h00, 8'h00);
    add_row(OP_DATA, 8'h00, 8'h00, 8'h00, 8'h00);
    add_row(OP_EXEC, OPC_LD_MHL_N, 8'hA5, 8'h00, 8'h00);
    add_row(OP_EXEC, OPC_ADD_HLSP, 8'h00, 8'h00, 8'h00);
    add_row(OP_EXEC, OPC_JR, 8'h80, 8'h00, 8'h00);
    add_row(OP_EXEC, OPC_JR_NZ, 8'h7F, 8'h00, 8'h00);
    add_row(OP_EXEC, OPC_CPL, 8'h00, 8'h00, 8'h00);
    add_row(OP_EXEC, OPC_SCF, 8'h00, 8'h00, 8'h00);
    add_row(OP_EXEC, OPC_RRA, 8'h00, 8'h00, 8'h00);
    add_row(OP_EXEC, OPC_CCF, 8'h00, 8'h00, 8'h00);
    add_row(OP_EXEC, OPC_SBC_A, 8'h00, 8'h00, 8'h00);
    add_row(OP_EXEC, OPC_CP_MHL, 8'h00, 8'h00, 8'h00);
    add_row(OP_DATA, 8'h00, 8'h00, 8'h00, 8'h01);
    add_row(OP_EXEC, OPC_LD_B_MHL, 8'h00, 8'h00, 8'h00); // dropped by the next instruction
    add_row(OP_EXEC, OPC_ADC_MHL, 8'h00, 8'h00, 8'h00);
    add_row(OP_DATA, 8'h00, 8'h00, 8'h00, 8'hFF);
    add_row(OP_EXEC, OPC_HALT, 8'h00, 8'h00, 8'h00);
    add_row(OP_EXEC, OPC_LAST, 8'hFF, 8'hFF, 8'hFF);

    foreach (table_rows[i]) begin
      send_item(table_rows[i].op, table_rows[i].opcode, table_rows[i].lo,
                table_rows[i].hi, table_rows[i].rd);
      // Typed rows replace the predicted expectation by the hand-written one
      if (table_rows[i].typed && expected_results.size() != 0)
        expected_results[expected_results.size() - 1] = table_rows[i].want;
    end

    fork
      hold_receiver();
      repeat (20) random_item();
    join

    // Pause the sender until the core has drained
    wait_drained();

    while (sent < 150) random_item();
    send_idle_pct = 79;
    recv_idle_pct = 24;
    while (sent < 260) random_item();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (sent < 375) random_item();

    wait_drained();
    if (errors == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
